@@ sv/lav_pkg.sv @@
`timescale 1ns / 1ps

package lav_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 24;

	// shared multiplier operand and product widths
	localparam int MW = 33;
	localparam int PW = 2 * MW;

	// sequencer step counter
	localparam int CNT_W = 6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIVINIT,
		ST_DIV,
		ST_CROSS,
		ST_CLOAD,
		ST_TRUEUP,
		ST_UROUND,
		ST_DOT,
		ST_TROUND,
		ST_WRITE
	} lav_state_t;

	// shift right by fb, rounding half away from zero
	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int fb);
		logic [PW-1:0] m;
		logic [PW-1:0] q;
		m = v[PW-1] ? (~v + 1'b1) : v;
		q = (m + (PW'(1) << (fb - 1))) >> fb;
		return v[PW-1] ? -$signed(q) : $signed(q);
	endfunction

endpackage

@@ sv/lav_fifo.sv @@
`timescale 1ns / 1ps

module lav_fifo #(
	parameter int DW = 8,
	parameter int LOG = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);

	localparam int DEPTH = 1 << LOG;

	logic [DW-1:0]  mem_q [DEPTH];
	logic [LOG-1:0] wr_q;
	logic [LOG-1:0] rd_q;
	logic [LOG:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = cnt_q == (LOG+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

@@ sv/lav_front.sv @@
`timescale 1ns / 1ps

module lav_front #(
	parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [9*COORD_WIDTH-1:0]        in_data,
	output logic                            q_push,
	input  logic                            q_full,
	output logic [9*COORD_WIDTH+2:0]        q_data
);

	localparam int CW = COORD_WIDTH;

	logic                 v_s1;
	logic signed [CW-1:0] tg [3];
	logic signed [CW-1:0] ey [3];
	logic signed [CW:0]   d_s1 [3];
	logic [6*CW-1:0]      eu_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tg[i] = in_data[(9-i)*CW-1 -: CW];
			ey[i] = in_data[(6-i)*CW-1 -: CW];
		end
	end

	assign full   = v_s1 && q_full;
	assign q_push = v_s1 && !q_full;
	assign q_data = {d_s1[0], d_s1[1], d_s1[2], eu_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (push && !full) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	// forward difference taken at entry
	always_ff @(posedge clk) begin
		if (push && !full) begin
			for (int i = 0; i < 3; i++) d_s1[i] <= (CW+1)'(tg[i]) - (CW+1)'(ey[i]);
			eu_s1 <= in_data[6*CW-1:0];
		end
	end

endmodule

@@ sv/lav_back.sv @@
`timescale 1ns / 1ps

module lav_back #(
	parameter int FRAC_BITS   = lav_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_empty,
	input  logic [9*COORD_WIDTH+2:0]                 in_data,
	output logic                                     in_pop,
	input  logic                                     out_full,
	output logic                                     out_push,
	output logic [9*(FRAC_BITS+2)+3*(COORD_WIDTH+2)-1:0] out_data
);

	localparam int FB = FRAC_BITS;
	localparam int CW = COORD_WIDTH;
	localparam int RW = FB + 2;
	localparam int SW = CW + 2;
	localparam int DW = CW + 1;
	localparam int VW = FB + CW + 2;
	localparam int MV = (VW > 31) ? VW : 31;
	localparam int QB = FB + 2;
	localparam int NW = 32 + FB;
	localparam int MW = lav_pkg::MW;
	localparam int PW = lav_pkg::PW;
	localparam int CNT_W = lav_pkg::CNT_W;

	localparam logic signed [PW-1:0] ONE  = PW'(1) <<< FB;
	localparam logic signed [PW-1:0] T_HI = (PW'(1) <<< (SW - 1)) - 1;
	localparam logic signed [PW-1:0] T_LO = -(PW'(1) <<< (SW - 1));

	lav_pkg::lav_state_t state_q, state_d;

	logic [CNT_W-1:0]     cnt_q;
	logic [1:0]           ci_q;
	logic                 phase_q;
	logic signed [VW-1:0] nv_q [3];
	logic [MV-1:0]        m_q [3];
	logic [2:0]           neg_q;
	logic signed [CW-1:0] eye_q [3];
	logic signed [CW-1:0] up_q [3];
	logic signed [RW-1:0] f_q [3];
	logic signed [RW-1:0] s_q [3];
	logic signed [RW-1:0] u_q [3];
	logic signed [SW-1:0] t_q [3];
	logic signed [PW-1:0] acc_q [3];
	logic signed [PW-1:0] prod_q;
	logic [63:0]          x_q;
	logic [63:0]          res_q;
	logic [63:0]          bit_q;
	logic [31:0]          len_q;
	logic [31:0]          rem_q;
	logic [QB-1:0]        dnum_q;
	logic [QB-1:0]        q_q;

	logic signed [MW-1:0] opa, opb;
	logic [1:0]           oidx;
	logic                 oneg;
	logic [3:0]           op;
	logic [3:0]           nops;
	logic                 mac_last;
	logic [MV-1:0]        mx;
	logic [63:0]          mx64;
	logic [63:0]          sq_sum;
	logic [NW-1:0]        num;
	logic [32:0]          dt;
	logic                 ge;
	logic [QB-1:0]        qn;
	logic [QB-1:0]        qc;
	logic signed [RW-1:0] nres;
	logic                 div_last;
	lav_pkg::lav_state_t  post_norm;

	assign op = cnt_q[4:1];

	always_comb begin
		nops = 4'd0;
		unique case (state_q)
			lav_pkg::ST_SQ:     nops = 4'd3;
			lav_pkg::ST_CROSS:  nops = 4'd6;
			lav_pkg::ST_TRUEUP: nops = 4'd6;
			lav_pkg::ST_DOT:    nops = 4'd9;
			default:            nops = 4'd0;
		endcase
	end

	assign mac_last = cnt_q[0] && (op == nops - 4'd1);

	// operand select for the shared multiplier
	always_comb begin
		opa  = '0;
		opb  = '0;
		oidx = 2'd0;
		oneg = 1'b0;
		case (state_q)
			lav_pkg::ST_SQ: begin
				case (op)
					4'd0:    begin opa = MW'($signed({1'b0, m_q[0][30:0]})); end
					4'd1:    begin opa = MW'($signed({1'b0, m_q[1][30:0]})); end
					default: begin opa = MW'($signed({1'b0, m_q[2][30:0]})); end
				endcase
				opb = opa;
			end
			lav_pkg::ST_CROSS: begin
				case (op)
					4'd0: begin opa = MW'(f_q[1]); opb = MW'(up_q[2]); oidx = 2'd0; end
					4'd1: begin opa = MW'(f_q[2]); opb = MW'(up_q[1]); oidx = 2'd0;
						oneg = 1'b1; end
					4'd2: begin opa = MW'(f_q[2]); opb = MW'(up_q[0]); oidx = 2'd1; end
					4'd3: begin opa = MW'(f_q[0]); opb = MW'(up_q[2]); oidx = 2'd1;
						oneg = 1'b1; end
					4'd4: begin opa = MW'(f_q[0]); opb = MW'(up_q[1]); oidx = 2'd2; end
					default: begin opa = MW'(f_q[1]); opb = MW'(up_q[0]); oidx = 2'd2;
						oneg = 1'b1; end
				endcase
			end
			lav_pkg::ST_TRUEUP: begin
				case (op)
					4'd0: begin opa = MW'(s_q[1]); opb = MW'(f_q[2]); oidx = 2'd0; end
					4'd1: begin opa = MW'(s_q[2]); opb = MW'(f_q[1]); oidx = 2'd0;
						oneg = 1'b1; end
					4'd2: begin opa = MW'(s_q[2]); opb = MW'(f_q[0]); oidx = 2'd1; end
					4'd3: begin opa = MW'(s_q[0]); opb = MW'(f_q[2]); oidx = 2'd1;
						oneg = 1'b1; end
					4'd4: begin opa = MW'(s_q[0]); opb = MW'(f_q[1]); oidx = 2'd2; end
					default: begin opa = MW'(s_q[1]); opb = MW'(f_q[0]); oidx = 2'd2;
						oneg = 1'b1; end
				endcase
			end
			lav_pkg::ST_DOT: begin
				case (op)
					4'd0: begin opa = MW'(s_q[0]); opb = MW'(eye_q[0]); oidx = 2'd0; end
					4'd1: begin opa = MW'(s_q[1]); opb = MW'(eye_q[1]); oidx = 2'd0; end
					4'd2: begin opa = MW'(s_q[2]); opb = MW'(eye_q[2]); oidx = 2'd0; end
					4'd3: begin opa = MW'(u_q[0]); opb = MW'(eye_q[0]); oidx = 2'd1; end
					4'd4: begin opa = MW'(u_q[1]); opb = MW'(eye_q[1]); oidx = 2'd1; end
					4'd5: begin opa = MW'(u_q[2]); opb = MW'(eye_q[2]); oidx = 2'd1; end
					4'd6: begin opa = MW'(f_q[0]); opb = MW'(eye_q[0]); oidx = 2'd2; end
					4'd7: begin opa = MW'(f_q[1]); opb = MW'(eye_q[1]); oidx = 2'd2; end
					default: begin opa = MW'(f_q[2]); opb = MW'(eye_q[2]); oidx = 2'd2; end
				endcase
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	// largest magnitude for the scaling loop
	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
		mx64 = 64'(mx);
	end

	assign sq_sum = res_q + bit_q;

	// divider datapath
	assign num      = (NW'(m_q[ci_q][30:0]) << FB) + NW'(len_q[31:1]);
	assign dt       = {rem_q, dnum_q[QB-1]};
	assign ge       = dt >= {1'b0, len_q};
	assign qn       = {q_q[QB-2:0], ge};
	assign qc       = (qn > (QB'(1) << FB)) ? (QB'(1) << FB) : qn;
	assign nres     = neg_q[ci_q] ? -$signed(qc) : $signed(qc);
	assign div_last = cnt_q == CNT_W'(QB - 1);

	assign post_norm = phase_q ? lav_pkg::ST_TRUEUP : lav_pkg::ST_CROSS;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lav_pkg::ST_IDLE:    if (!in_empty) state_d = lav_pkg::ST_MAG;
			lav_pkg::ST_MAG:     state_d = lav_pkg::ST_SHIFT;
			lav_pkg::ST_SHIFT: begin
				if (mx64 == 64'd0) state_d = post_norm;
				else if (mx64 >= 64'h8000_0000) state_d = lav_pkg::ST_SHIFT;
				else if (mx64 < 64'h4000_0000) state_d = lav_pkg::ST_SHIFT;
				else state_d = lav_pkg::ST_SQ;
			end
			lav_pkg::ST_SQ:      if (mac_last) state_d = lav_pkg::ST_SQRT;
			lav_pkg::ST_SQRT:    if (cnt_q == CNT_W'(31)) state_d = lav_pkg::ST_DIVINIT;
			lav_pkg::ST_DIVINIT: state_d = lav_pkg::ST_DIV;
			lav_pkg::ST_DIV: begin
				if (div_last) state_d = (ci_q == 2'd2) ? post_norm : lav_pkg::ST_DIVINIT;
			end
			lav_pkg::ST_CROSS:   if (mac_last) state_d = lav_pkg::ST_CLOAD;
			lav_pkg::ST_CLOAD:   state_d = lav_pkg::ST_MAG;
			lav_pkg::ST_TRUEUP:  if (mac_last) state_d = lav_pkg::ST_UROUND;
			lav_pkg::ST_UROUND:  state_d = lav_pkg::ST_DOT;
			lav_pkg::ST_DOT:     if (mac_last) state_d = lav_pkg::ST_TROUND;
			lav_pkg::ST_TROUND:  state_d = lav_pkg::ST_WRITE;
			lav_pkg::ST_WRITE:   if (!out_full) state_d = lav_pkg::ST_IDLE;
			default:             state_d = lav_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_pop   = (state_q == lav_pkg::ST_IDLE) && !in_empty;
		out_push = (state_q == lav_pkg::ST_WRITE) && !out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lav_pkg::ST_IDLE;
			cnt_q   <= '0;
			ci_q    <= 2'd0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			if (state_q == lav_pkg::ST_SQRT) ci_q <= 2'd0;
			else if (state_q == lav_pkg::ST_DIV && div_last) ci_q <= ci_q + 2'd1;
			if (state_q == lav_pkg::ST_IDLE) phase_q <= 1'b0;
			else if (state_q == lav_pkg::ST_CLOAD) phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lav_pkg::ST_SQ, lav_pkg::ST_CROSS, lav_pkg::ST_TRUEUP, lav_pkg::ST_DOT,
			lav_pkg::ST_CLOAD, lav_pkg::ST_TROUND: begin
			end
			default: begin
				for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			end
		endcase

		case (state_q)
			lav_pkg::ST_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					nv_q[i]  <= VW'($signed(in_data[9*CW+3-i*DW-1 -: DW]));
					eye_q[i] <= in_data[6*CW-1-i*CW -: CW];
					up_q[i]  <= in_data[3*CW-1-i*CW -: CW];
				end
			end
			lav_pkg::ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= MV'(nv_q[i][VW-1] ? (~nv_q[i] + 1'b1) : nv_q[i]);
					neg_q[i] <= nv_q[i][VW-1];
				end
			end
			lav_pkg::ST_SHIFT: begin
				if (mx64 == 64'd0) begin
					// zero length vector gives a zero row
					for (int i = 0; i < 3; i++) begin
						if (phase_q) s_q[i] <= '0;
						else f_q[i] <= '0;
					end
				end else if (mx64 >= 64'h8000_0000) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (mx64 < 64'h4000_0000) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end
			end
			lav_pkg::ST_SQRT: begin
				if (x_q >= sq_sum) begin
					x_q   <= x_q - sq_sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				len_q <= 32'(((x_q >= sq_sum) ? ((res_q >> 1) + bit_q) : (res_q >> 1)));
			end
			lav_pkg::ST_DIVINIT: begin
				rem_q  <= 32'(num[NW-1:QB]);
				dnum_q <= num[QB-1:0];
				q_q    <= '0;
			end
			lav_pkg::ST_DIV: begin
				rem_q  <= ge ? 32'(dt - {1'b0, len_q}) : dt[31:0];
				dnum_q <= dnum_q << 1;
				q_q    <= qn;
				if (div_last) begin
					if (phase_q) s_q[ci_q] <= nres;
					else f_q[ci_q] <= nres;
				end
			end
			lav_pkg::ST_CLOAD: begin
				for (int i = 0; i < 3; i++) nv_q[i] <= acc_q[i][VW-1:0];
			end
			lav_pkg::ST_UROUND: begin
				for (int i = 0; i < 3; i++) begin
					if (lav_pkg::rnd(acc_q[i], FB) > ONE) u_q[i] <= RW'(ONE);
					else if (lav_pkg::rnd(acc_q[i], FB) < -ONE) u_q[i] <= RW'(-ONE);
					else u_q[i] <= RW'(lav_pkg::rnd(acc_q[i], FB));
				end
			end
			lav_pkg::ST_TROUND: begin
				for (int i = 0; i < 3; i++) begin
					logic signed [PW-1:0] r;
					r = (i == 2) ? lav_pkg::rnd(acc_q[i], FB) : -lav_pkg::rnd(acc_q[i], FB);
					if (r > T_HI) t_q[i] <= SW'(T_HI);
					else if (r < T_LO) t_q[i] <= SW'(T_LO);
					else t_q[i] <= SW'(r);
				end
			end
			default: begin
			end
		endcase

		// multiply on even steps, accumulate on odd steps
		case (state_q)
			lav_pkg::ST_SQ, lav_pkg::ST_CROSS, lav_pkg::ST_TRUEUP, lav_pkg::ST_DOT: begin
				if (!cnt_q[0]) begin
					prod_q <= opa * opb;
				end else begin
					acc_q[oidx] <= oneg ? acc_q[oidx] - prod_q : acc_q[oidx] + prod_q;
				end
				if (state_q == lav_pkg::ST_SQ && mac_last) begin
					x_q   <= 64'(acc_q[0] + prod_q);
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_data = {s_q[0], s_q[1], s_q[2], t_q[0],
		u_q[0], u_q[1], u_q[2], t_q[1],
		RW'(-f_q[0]), RW'(-f_q[1]), RW'(-f_q[2]), t_q[2]};

endmodule

@@ sv/look_at_view_matrix_unit.sv @@
`timescale 1ns / 1ps
// the sequencer takes a new item only once the last one is written out; a pass is shorter when
// the up hint gives no side vector and shortest when eye equals target
// the bit-serial square root (32 steps), the three restoring divides and the one bit per
// cycle scaling loop of each normalize dominate a pass
// up to three input beats are taken back to back into the front stage and queue
// reset: asynchronous active low, empties both queues and returns the sequencer to idle

module look_at_view_matrix_unit #(
	parameter int FRAC_BITS   = lav_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] target_x,
	input  logic signed [COORD_WIDTH-1:0] target_y,
	input  logic signed [COORD_WIDTH-1:0] target_z,
	input  logic signed [COORD_WIDTH-1:0] eye_x,
	input  logic signed [COORD_WIDTH-1:0] eye_y,
	input  logic signed [COORD_WIDTH-1:0] eye_z,
	input  logic signed [COORD_WIDTH-1:0] up_x,
	input  logic signed [COORD_WIDTH-1:0] up_y,
	input  logic signed [COORD_WIDTH-1:0] up_z,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [FRAC_BITS+1:0]   side_x,
	output logic signed [FRAC_BITS+1:0]   side_y,
	output logic signed [FRAC_BITS+1:0]   side_z,
	output logic signed [COORD_WIDTH+1:0] side_shift,
	output logic signed [FRAC_BITS+1:0]   trueup_x,
	output logic signed [FRAC_BITS+1:0]   trueup_y,
	output logic signed [FRAC_BITS+1:0]   trueup_z,
	output logic signed [COORD_WIDTH+1:0] trueup_shift,
	output logic signed [FRAC_BITS+1:0]   back_x,
	output logic signed [FRAC_BITS+1:0]   back_y,
	output logic signed [FRAC_BITS+1:0]   back_z,
	output logic signed [COORD_WIDTH+1:0] back_shift
);

	localparam int RW = FRAC_BITS + 2;
	localparam int SW = COORD_WIDTH + 2;
	localparam int QW = 9 * COORD_WIDTH + 3;
	localparam int OW = 9 * RW + 3 * SW;
	localparam int ROW = 3 * RW + SW;

	logic          fq_push, fq_full, fq_empty, fq_pop;
	logic [QW-1:0] fq_wdata, fq_rdata;
	logic          oq_push, oq_full;
	logic [OW-1:0] oq_wdata, oq_rdata;

	lav_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_data ({target_x, target_y, target_z, eye_x, eye_y, eye_z, up_x, up_y, up_z}),
		.q_push  (fq_push),
		.q_full  (fq_full),
		.q_data  (fq_wdata)
	);

	lav_fifo #(.DW(QW), .LOG(1)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_wdata),
		.full   (fq_full),
		.pop    (fq_pop),
		.rdata  (fq_rdata),
		.empty  (fq_empty)
	);

	lav_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (fq_empty),
		.in_data  (fq_rdata),
		.in_pop   (fq_pop),
		.out_full (oq_full),
		.out_push (oq_push),
		.out_data (oq_wdata)
	);

	lav_fifo #(.DW(OW), .LOG(1)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_wdata),
		.full   (oq_full),
		.pop    (pop),
		.rdata  (oq_rdata),
		.empty  (empty)
	);

	assign side_x       = oq_rdata[OW-1 -: RW];
	assign side_y       = oq_rdata[OW-1-RW -: RW];
	assign side_z       = oq_rdata[OW-1-2*RW -: RW];
	assign side_shift   = oq_rdata[OW-1-3*RW -: SW];
	assign trueup_x     = oq_rdata[OW-1-ROW -: RW];
	assign trueup_y     = oq_rdata[OW-1-ROW-RW -: RW];
	assign trueup_z     = oq_rdata[OW-1-ROW-2*RW -: RW];
	assign trueup_shift = oq_rdata[OW-1-ROW-3*RW -: SW];
	assign back_x       = oq_rdata[OW-1-2*ROW -: RW];
	assign back_y       = oq_rdata[OW-1-2*ROW-RW -: RW];
	assign back_z       = oq_rdata[OW-1-2*ROW-2*RW -: RW];
	assign back_shift   = oq_rdata[SW-1:0];

endmodule

@@ tb/tb_look_at_view_matrix_unit.sv @@
`timescale 1ns / 1ps

module tb_look_at_view_matrix_unit;

	localparam int FB = lav_pkg::FRAC_BITS_DEF;
	localparam int CW = lav_pkg::COORD_WIDTH_DEF;
	localparam int RW = FB + 2;
	localparam int SW = CW + 2;
	localparam longint ONE = 64'sd1 <<< FB;
	localparam int CYCLE_LIMIT = 2000000;

	typedef longint vec3_t [3];

	typedef struct {
		logic signed [RW-1:0] side_x, side_y, side_z;
		logic signed [SW-1:0] side_shift;
		logic signed [RW-1:0] trueup_x, trueup_y, trueup_z;
		logic signed [SW-1:0] trueup_shift;
		logic signed [RW-1:0] back_x, back_y, back_z;
		logic signed [SW-1:0] back_shift;
	} view_rows_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [CW-1:0] target_x = '0, target_y = '0, target_z = '0;
	logic signed [CW-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
	logic signed [CW-1:0] up_x = '0, up_y = '0, up_z = '0;
	logic signed [RW-1:0] side_x, side_y, side_z, trueup_x, trueup_y, trueup_z;
	logic signed [RW-1:0] back_x, back_y, back_z;
	logic signed [SW-1:0] side_shift, trueup_shift, back_shift;

	view_rows_t pending_views[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	int pop_hold = 0;

	look_at_view_matrix_unit DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.empty(empty), .pop(pop),
		.side_x(side_x), .side_y(side_y), .side_z(side_z), .side_shift(side_shift),
		.trueup_x(trueup_x), .trueup_y(trueup_y), .trueup_z(trueup_z),
		.trueup_shift(trueup_shift),
		.back_x(back_x), .back_y(back_y), .back_z(back_z), .back_shift(back_shift)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// scale the largest magnitude into [2^30, 2^31) before the length
	function automatic vec3_t unit_vec(vec3_t v);
		longint unsigned m[3], mx, sq, len, q;
		vec3_t n;
		mx = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx)
				mx = m[i];
			n[i] = 0;
		end
		if (mx == 0)
			return n;
		while (mx >= (64'd1 << 31)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sq += m[i] * m[i];
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + len / 2) / len;
			if (q > ONE)
				q = ONE;
			n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return n;
	endfunction

	function automatic longint round_away(longint v);
		longint unsigned q;
		q = ((v < 0 ? -v : v) + (64'd1 << (FB - 1))) >> FB;
		return v < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic view_rows_t look_at(vec3_t tg, vec3_t ey, vec3_t up);
		vec3_t d, f, c, s, u;
		longint tlo, thi;
		view_rows_t r;
		tlo = -(64'sd1 <<< (SW - 1));
		thi = (64'sd1 <<< (SW - 1)) - 1;
		for (int i = 0; i < 3; i++)
			d[i] = tg[i] - ey[i];
		f = unit_vec(d);
		c[0] = f[1] * up[2] - f[2] * up[1];
		c[1] = f[2] * up[0] - f[0] * up[2];
		c[2] = f[0] * up[1] - f[1] * up[0];
		s = unit_vec(c);
		u[0] = clip(round_away(s[1] * f[2] - s[2] * f[1]), -ONE, ONE);
		u[1] = clip(round_away(s[2] * f[0] - s[0] * f[2]), -ONE, ONE);
		u[2] = clip(round_away(s[0] * f[1] - s[1] * f[0]), -ONE, ONE);
		r.side_x = RW'(s[0]);
		r.side_y = RW'(s[1]);
		r.side_z = RW'(s[2]);
		r.trueup_x = RW'(u[0]);
		r.trueup_y = RW'(u[1]);
		r.trueup_z = RW'(u[2]);
		r.back_x = RW'(-f[0]);
		r.back_y = RW'(-f[1]);
		r.back_z = RW'(-f[2]);
		r.side_shift = SW'(clip(-round_away(s[0] * ey[0] + s[1] * ey[1] + s[2] * ey[2]),
			tlo, thi));
		r.trueup_shift = SW'(clip(-round_away(u[0] * ey[0] + u[1] * ey[1] + u[2] * ey[2]),
			tlo, thi));
		r.back_shift = SW'(clip(round_away(f[0] * ey[0] + f[1] * ey[1] + f[2] * ey[2]),
			tlo, thi));
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// result side: compare each popped beat, then choose the next pop level
	always @(posedge clk) begin
		view_rows_t w;
		if (arst_n && pop && !empty) begin
			if (pending_views.size() == 0) begin
				errors++;
				$display("%0t result beat with nothing expected", $time);
			end else begin
				w = pending_views.pop_front();
				check_field("side_x", w.side_x, side_x);
				check_field("side_y", w.side_y, side_y);
				check_field("side_z", w.side_z, side_z);
				check_field("side_shift", w.side_shift, side_shift);
				check_field("trueup_x", w.trueup_x, trueup_x);
				check_field("trueup_y", w.trueup_y, trueup_y);
				check_field("trueup_z", w.trueup_z, trueup_z);
				check_field("trueup_shift", w.trueup_shift, trueup_shift);
				check_field("back_x", w.back_x, back_x);
				check_field("back_y", w.back_y, back_y);
				check_field("back_z", w.back_z, back_z);
				check_field("back_shift", w.back_shift, back_shift);
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			pop_hold <= $urandom_range(0, 18);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_item(vec3_t tg, vec3_t ey, vec3_t up);
		push <= 1'b1;
		target_x <= CW'(tg[0]);
		target_y <= CW'(tg[1]);
		target_z <= CW'(tg[2]);
		eye_x <= CW'(ey[0]);
		eye_y <= CW'(ey[1]);
		eye_z <= CW'(ey[2]);
		up_x <= CW'(up[0]);
		up_y <= CW'(up[1]);
		up_z <= CW'(up[2]);
		do
			@(posedge clk);
		while (full);
		pending_views.push_back(look_at(tg, ey, up));
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	function automatic longint any_coord();
		return longint'($signed(CW'($urandom())));
	endfunction

	function automatic longint near_coord();
		return longint'($signed($urandom_range(0, 2 * 8192))) - 8192;
	endfunction

	task automatic test_directed();
		longint hi, lo;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		lo = -(64'sd1 <<< (CW - 1));
		// eye equal to target
		send_item('{5, -7, 9}, '{5, -7, 9}, '{0, ONE, 0});
		send_item('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
		// up hint zero, then parallel to the view direction
		send_item('{ONE, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
		send_item('{0, 3 * ONE, 0}, '{0, ONE, 0}, '{0, -ONE, 0});
		send_item('{hi, hi, hi}, '{lo, lo, lo}, '{hi, hi, hi});
		// ordinary cameras, the first looking down minus z
		send_item('{0, 0, 0}, '{0, 0, 5 * ONE}, '{0, ONE, 0});
		send_item('{ONE, 2 * ONE, -ONE}, '{-3 * ONE, ONE, 4 * ONE}, '{0, 0, ONE});
		// field extremes, large translations and minimal vectors
		send_item('{hi, lo, hi}, '{lo, hi, lo}, '{lo, hi, 0});
		send_item('{lo, lo, lo}, '{hi, hi, hi}, '{hi, lo, hi});
		send_item('{hi, 0, 0}, '{lo, hi, lo}, '{0, lo, 0});
		send_item('{0, 0, lo}, '{hi, lo, hi}, '{lo, 0, 0});
		send_item('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
		send_item('{-1, -1, -1}, '{hi, hi, hi}, '{1, -1, 1});
		send_item('{lo, 0, hi}, '{0, 0, 0}, '{-1, -1, -1});
	endtask

	task automatic random_item();
		vec3_t tg, ey, up;
		int k;
		for (int i = 0; i < 3; i++) begin
			tg[i] = any_coord();
			ey[i] = any_coord();
			up[i] = any_coord();
		end
		case ($urandom_range(0, 9))
			0: ey = tg;
			1: begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < 3; i++) begin
					tg[i] = near_coord();
					ey[i] = near_coord();
					up[i] = (tg[i] - ey[i]) * (($urandom_range(0, 1) != 0) ? k : -k);
				end
			end
			2: up = '{0, 0, 0};
			3, 4: begin
				for (int i = 0; i < 3; i++) begin
					tg[i] = near_coord();
					ey[i] = near_coord();
					up[i] = near_coord();
				end
			end
			default: ;
		endcase
		send_item(tg, ey, up);
	endtask

	task automatic test_random(int n);
		repeat (n) random_item();
	endtask

	task automatic test_no_idle(int n);
		calm = 1'b1;
		repeat (n) random_item();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400);
		test_no_idle(50);
		push <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending_views.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
